// File: hdl/vox_pkg.sv
// Package for the VOX ADPCM word decoder: codes, the step table and the
// channel state type. No dependencies.
package vox_pkg;

    localparam logic [15:0] END_MARKER = 16'hFFFF;
    localparam logic [15:0] SIGN_FLIP  = 16'h8000;
    localparam logic [5:0]  STEP_MAX   = 6'd48;

    localparam int PRED_W = 12;
    localparam int IDX_W  = 6;
    localparam int STEP_W = 11;

    typedef struct packed {
        logic signed [PRED_W-1:0] pred;
        logic [IDX_W-1:0]         idx;
    } t_chan_state;

    function automatic logic [STEP_W-1:0] step_lookup(input logic [IDX_W-1:0] idx);
        logic [STEP_W-1:0] s;
        begin
            unique case (idx)
                6'd0:  s = 11'd16;
                6'd1:  s = 11'd17;
                6'd2:  s = 11'd19;
                6'd3:  s = 11'd21;
                6'd4:  s = 11'd23;
                6'd5:  s = 11'd25;
                6'd6:  s = 11'd28;
                6'd7:  s = 11'd31;
                6'd8:  s = 11'd34;
                6'd9:  s = 11'd37;
                6'd10: s = 11'd41;
                6'd11: s = 11'd45;
                6'd12: s = 11'd50;
                6'd13: s = 11'd55;
                6'd14: s = 11'd60;
                6'd15: s = 11'd66;
                6'd16: s = 11'd73;
                6'd17: s = 11'd80;
                6'd18: s = 11'd88;
                6'd19: s = 11'd97;
                6'd20: s = 11'd107;
                6'd21: s = 11'd118;
                6'd22: s = 11'd130;
                6'd23: s = 11'd143;
                6'd24: s = 11'd157;
                6'd25: s = 11'd173;
                6'd26: s = 11'd190;
                6'd27: s = 11'd209;
                6'd28: s = 11'd230;
                6'd29: s = 11'd253;
                6'd30: s = 11'd279;
                6'd31: s = 11'd307;
                6'd32: s = 11'd337;
                6'd33: s = 11'd371;
                6'd34: s = 11'd408;
                6'd35: s = 11'd449;
                6'd36: s = 11'd494;
                6'd37: s = 11'd544;
                6'd38: s = 11'd598;
                6'd39: s = 11'd658;
                6'd40: s = 11'd724;
                6'd41: s = 11'd796;
                6'd42: s = 11'd876;
                6'd43: s = 11'd963;
                6'd44: s = 11'd1060;
                6'd45: s = 11'd1166;
                6'd46: s = 11'd1282;
                6'd47: s = 11'd1411;
                default: s = 11'd1552;
            endcase
            return s;
        end
    endfunction

    function automatic logic signed [4:0] index_move(input logic [2:0] mag);
        logic signed [4:0] m;
        begin
            unique case (mag)
                3'd4:    m = 5'sd2;
                3'd5:    m = 5'sd4;
                3'd6:    m = 5'sd6;
                3'd7:    m = 5'sd8;
                default: m = -5'sd1;
            endcase
            return m;
        end
    endfunction

endpackage

// File: hdl/vox_nib_dec.sv
// One ADPCM nibble decode: predictor update with saturation and step index
// update with clamping. Depends on vox_pkg.
module vox_nib_dec (
    input  vox_pkg::t_chan_state i_state,
    input  logic [3:0]           i_code,
    output vox_pkg::t_chan_state o_state
);
    import vox_pkg::*;

    logic [STEP_W-1:0]  step;
    logic [STEP_W+1:0]  diff;
    logic signed [13:0] sum;
    logic signed [4:0]  mv;
    logic signed [6:0]  ni;

    always_comb begin
        step = step_lookup(i_state.idx);
        diff = {5'b00000, step[STEP_W-1:3]};
        if (i_code[0]) diff = diff + {4'b0000, step[STEP_W-1:2]};
        if (i_code[1]) diff = diff + {3'b000, step[STEP_W-1:1]};
        if (i_code[2]) diff = diff + {2'b00, step};

        if (i_code[3]) begin
            sum = {{2{i_state.pred[PRED_W-1]}}, i_state.pred} - $signed({1'b0, diff});
        end else begin
            sum = {{2{i_state.pred[PRED_W-1]}}, i_state.pred} + $signed({1'b0, diff});
        end

        if (sum > 14'sd2047) begin
            o_state.pred = 12'sd2047;
        end else if (sum < -14'sd2048) begin
            o_state.pred = -12'sd2048;
        end else begin
            o_state.pred = sum[PRED_W-1:0];
        end

        mv = index_move(i_code[2:0]);
        ni = $signed({1'b0, i_state.idx}) + $signed({{2{mv[4]}}, mv});
        if (ni < 7'sd0) begin
            o_state.idx = '0;
        end else if (ni > $signed({1'b0, STEP_MAX})) begin
            o_state.idx = STEP_MAX;
        end else begin
            o_state.idx = ni[IDX_W-1:0];
        end
    end

endmodule

// File: hdl/vox_adpcm_word_decoder.sv
// Top level of the VOX ADPCM word decoder: input register, nibble sequencing,
// channel state and output register. Depends on vox_pkg and vox_nib_dec.
//
// An ordinary word gives four results, one per nibble, low nibble first, and
// occupies the decoder until its last nibble issues, because each nibble decode
// feeds the predictor and step index of the next through a single decode unit.
// The end marker 0xFFFF gives one result. Each result appears in the output
// register in the cycle after its decode; the next word is taken in the cycle
// its predecessor issues its last result, so words follow each other without
// a gap while the output is not stalled.
module vox_adpcm_word_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [15:0] i_wave_word,
    input  logic        i_restart,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_sample_word,
    output logic        o_end_seen,
    output logic        o_stop_channel,
    output logic        o_last_of_word
);
    import vox_pkg::*;

    logic        r_one_shot;
    logic        r_busy;
    logic [1:0]  r_nib;
    logic [15:0] r_word;
    logic        r_restart;
    t_chan_state r_state;
    t_chan_state cur_state;
    t_chan_state n_state;

    logic        issue;
    logic        is_end;
    logic        done;
    logic        accept;
    logic [3:0]  code;

    assign issue      = r_busy && (!o_out_valid || !i_out_stall);
    assign is_end     = (r_word == END_MARKER);
    assign done       = issue && (is_end || (r_nib == 2'd3));
    assign o_in_stall = r_busy && !done;
    assign accept     = i_in_valid && !o_in_stall;
    assign code       = r_word[{r_nib, 2'b00} +: 4];

    always_comb begin
        if (r_restart && (r_nib == 2'd0)) begin
            cur_state = '0;
        end else begin
            cur_state = r_state;
        end
    end

    vox_nib_dec u_dec (
        .i_state (cur_state),
        .i_code  (code),
        .o_state (n_state)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_one_shot <= 1'b0;
        end else if (i_cfg_we) begin
            r_one_shot <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_nib   <= 2'd0;
            r_state <= '0;
        end else begin
            if (accept) begin
                r_busy <= 1'b1;
                r_nib  <= 2'd0;
            end else if (done) begin
                r_busy <= 1'b0;
            end else if (issue) begin
                r_nib <= r_nib + 2'd1;
            end
            if (issue) begin
                r_state <= is_end ? '0 : n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_word    <= i_wave_word;
            r_restart <= i_restart;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (issue) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            if (is_end) begin
                o_sample_word  <= '0;
                o_end_seen     <= 1'b1;
                o_stop_channel <= r_one_shot;
                o_last_of_word <= 1'b1;
            end else begin
                o_sample_word  <= {{4{n_state.pred[PRED_W-1]}}, n_state.pred} ^ SIGN_FLIP;
                o_end_seen     <= 1'b0;
                o_stop_channel <= 1'b0;
                o_last_of_word <= (r_nib == 2'd3);
            end
        end
    end

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.idx <= STEP_MAX)
        else $error("step index out of range");

    a_end_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_end_seen |-> (o_sample_word == 16'h0000) && o_last_of_word)
        else $error("end result malformed");

    a_stop_only_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_stop_channel |-> o_end_seen)
        else $error("stop without end marker");

    a_nib_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        issue && !done |=> r_busy && (r_nib == $past(r_nib) + 2'd1))
        else $error("nibble sequence slipped");

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        issue && is_end |=> (r_state.pred == 12'sd0) && (r_state.idx == 6'd0))
        else $error("end marker left state");

endmodule
